/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* src/pbfe_pkg.sv */
// ---------------------------------------------------------------------------
// pbfe_pkg
// Types and constants shared by the wire-format field encoder.
// ---------------------------------------------------------------------------
package pbfe_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned FieldWidth  = 29;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned FixedBytes  = 8;
  localparam int unsigned FixCntWidth = 3;

  // Opcodes other than OP_PAYLOAD double as wire types for the tag
  localparam logic [1:0] OP_VARINT  = 2'd0;
  localparam logic [1:0] OP_FIXED64 = 2'd1;
  localparam logic [1:0] OP_LENGTH  = 2'd2;
  localparam logic [1:0] OP_PAYLOAD = 2'd3;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [FieldWidth-1:0] field_no;
    logic [ValueWidth-1:0] value;
  } pbfe_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] byte_out;
    logic                 last;
  } pbfe_result_t;

  // Shift register control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
    logic by8;
  } pbfe_sreg_ctrl_t;

endpackage

/* src/pbfe_digit_sreg.sv */
// ---------------------------------------------------------------------------
// pbfe_digit_sreg
// 64-bit shift register, one 7-bit group or one byte out per cycle while shift is set.
// ---------------------------------------------------------------------------
module pbfe_digit_sreg
  import pbfe_pkg::*;
(
  input  logic                  clk_i,
  input  pbfe_sreg_ctrl_t       ctrl_i,
  input  logic [ValueWidth-1:0] load_data_i,
  output logic [ByteWidth-1:0]  digit_o,
  output logic                  more_o
);

  logic [ValueWidth-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = ctrl_i.by8 ? (data_q >> 8) : (data_q >> 7);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign digit_o = data_q[ByteWidth-1:0];
  // varint continuation: anything left above the current group
  assign more_o  = |data_q[ValueWidth-1:7];

endmodule

/* src/protobuf_field_encoder.sv */
// ---------------------------------------------------------------------------
// protobuf_field_encoder
// Serialises wire-format fields (tag + varint / fixed64 / length) and payload to bytes.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------
//  item     | start_i high, busy_o low | item_i  (pbfe_item_t)
//  result   | strobe_o, one cycle    | result_o (pbfe_result_t)
//
// One byte per cycle once the tag starts, from a single 64-bit digit shift
// register: the tag first, then the value reloaded from a holding register.
// A payload item is one byte, out in the cycle after the transfer; a field's
// first byte passes the shift register, then the result register. busy_o
// drops with the last byte on the port. Reset clears the sequencer and the
// result strobe; results cannot be held off, so nothing stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module protobuf_field_encoder
  import pbfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  pbfe_item_t   item_i,
  output logic         strobe_o,
  output pbfe_result_t result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_VAR,
    ST_FIX
  } state_e;

  state_e                 state_q;
  logic [1:0]             op_q;
  logic [ValueWidth-1:0]  value_q;
  logic [FixCntWidth-1:0] cnt_q;
  logic                   strobe_q;
  pbfe_result_t           result_q;

  pbfe_sreg_ctrl_t        sreg_ctrl;
  logic [ValueWidth-1:0]  sreg_load;
  logic [ByteWidth-1:0]   digit;
  logic                   more;
  logic                   accept;
  logic [ValueWidth-1:0]  tag_word;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign tag_word = {32'd0, item_i.field_no, 1'b0, item_i.opcode};

  always_comb begin
    sreg_ctrl = '0;
    sreg_load = tag_word;
    case (state_q)
      ST_IDLE: begin
        sreg_ctrl.load = accept && (item_i.opcode != OP_PAYLOAD);
      end
      ST_TAG: begin
        if (more) begin
          sreg_ctrl.shift = 1'b1;
        end else begin
          sreg_ctrl.load = 1'b1;
          sreg_load      = value_q;
        end
      end
      ST_VAR: begin
        sreg_ctrl.shift = 1'b1;
      end
      ST_FIX: begin
        sreg_ctrl.shift = 1'b1;
        sreg_ctrl.by8   = 1'b1;
      end
      default: begin
        sreg_ctrl = '0;
      end
    endcase
  end

  pbfe_digit_sreg u_sreg (
    .clk_i       (clk_i),
    .ctrl_i      (sreg_ctrl),
    .load_data_i (sreg_load),
    .digit_o     (digit),
    .more_o      (more)
  );

  // holding register for the value while the tag goes out
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= item_i.opcode;
      value_q <= item_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      result_q <= '0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (item_i.opcode == OP_PAYLOAD) begin
              strobe_q          <= 1'b1;
              result_q.byte_out <= item_i.value[ByteWidth-1:0];
              result_q.last     <= 1'b1;
            end else begin
              state_q <= ST_TAG;
            end
          end
        end
        ST_TAG: begin
          strobe_q          <= 1'b1;
          result_q.byte_out <= {more, digit[6:0]};
          result_q.last     <= 1'b0;
          cnt_q             <= '0;
          if (!more) begin
            state_q <= (op_q == OP_FIXED64) ? ST_FIX : ST_VAR;
          end
        end
        ST_VAR: begin
          strobe_q          <= 1'b1;
          result_q.byte_out <= {more, digit[6:0]};
          result_q.last     <= !more;
          if (!more) begin
            state_q <= ST_IDLE;
          end
        end
        ST_FIX: begin
          strobe_q          <= 1'b1;
          result_q.byte_out <= digit;
          result_q.last     <= (cnt_q == FixCntWidth'(FixedBytes - 1));
          cnt_q             <= cnt_q + 1'b1;
          if (cnt_q == FixCntWidth'(FixedBytes - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = result_q;

  // a payload byte comes out alone, marked last, with the block free again
  `ASSERT_PROP(a_payload_single, clk_i, rst_ni,
    (start_i && !busy_o && item_i.opcode == OP_PAYLOAD) |=>
      (strobe_o && result_o.last && !busy_o))
  // the cycle after a field transfer is busy but quiet, ahead of its first tag byte
  `ASSERT_PROP(a_field_busy, clk_i, rst_ni,
    (start_i && !busy_o && item_i.opcode != OP_PAYLOAD) |=> (busy_o && !strobe_o))
  // the eighth fixed64 byte closes the item
  `ASSERT_PROP(a_fix_last, clk_i, rst_ni,
    (state_q == ST_FIX && cnt_q == FixCntWidth'(FixedBytes - 1)) |=>
      (strobe_o && result_o.last && !busy_o))
  // no byte is flagged last while the sequencer still has bytes to send
  `ASSERT_NEVER(a_last_while_busy, clk_i, rst_ni,
    strobe_o && result_o.last && busy_o && $past(state_q) != ST_IDLE)

endmodule
